// ===== rtl/usvg_pkg.sv =====
`timescale 1ns / 1ps

package usvg_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_SEGS   = 2'd1;
    localparam logic [1:0] CFG_RINGS  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] RADIUS_RST = 16'd256;
    localparam logic [10:0] SEGS_RST   = 11'd16;
    localparam logic [10:0] RINGS_RST  = 11'd8;

    // Parameter defaults
    localparam int MAX_GRID_DEF   = 1024;
    localparam int ANGLE_BITS_DEF = 16;

    // Divisor width (segment_count / ring_count - 1)
    localparam int DIV_W = 11;

    // Sine polynomial coefficients, Q1.30
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd688904866;
    localparam logic [26:0] POLY_C = 27'd76016977;

    // Pipeline depth of the sine unit
    localparam int SIN_LAT = 6;

endpackage

// ===== rtl/usvg_dly.sv =====
`timescale 1ns / 1ps

module usvg_dly #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== rtl/usvg_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, optional trailing delay.
module usvg_div #(
    parameter int NUM_W = 28,
    parameter int QW    = 17,
    parameter int LAT   = 17
) (
    input  logic                       clk,
    input  logic [NUM_W-1:0]           num,
    input  logic [usvg_pkg::DIV_W-1:0] den,
    output logic [QW-1:0]              quot
);

    localparam int DW  = usvg_pkg::DIV_W;
    localparam int RW  = DW + 1;
    localparam int PAD = LAT - QW;

    logic [RW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            logic [RW-1:0] rem_prev;
            logic [QW-1:0] low_prev;
            logic [QW-1:0] quo_prev;
            logic [DW-1:0] den_prev;
            logic [RW-1:0] trial;
            logic          ge;

            if (s == 0)
            begin : g_first
                assign rem_prev = RW'(num[NUM_W-1:QW]);
                assign low_prev = num[QW-1:0];
                assign quo_prev = '0;
                assign den_prev = den;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[s-1];
                assign low_prev = low_reg[s-1];
                assign quo_prev = quo_reg[s-1];
                assign den_prev = den_reg[s-1];
            end

            assign trial = {rem_prev[RW-2:0], low_prev[QW-1]};
            assign ge    = (trial >= {1'b0, den_prev});

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? (trial - {1'b0, den_prev}) : trial;
                low_reg[s] <= {low_prev[QW-2:0], 1'b0};
                quo_reg[s] <= {quo_prev[QW-2:0], ge};
                den_reg[s] <= den_prev;
            end
        end

        if (PAD > 0)
        begin : g_pad
            logic [QW-1:0] pad_reg [PAD];

            always_ff @(posedge clk)
            begin
                pad_reg[0] <= quo_reg[QW-1];
                for (int i = 1; i < PAD; i++)
                begin
                    pad_reg[i] <= pad_reg[i-1];
                end
            end

            assign quot = pad_reg[PAD-1];
        end
        else
        begin : g_nopad
            assign quot = quo_reg[QW-1];
        end
    endgenerate

endmodule

// ===== rtl/usvg_sin.sv =====
`timescale 1ns / 1ps

// Sine of a phase, Q1.15 result, SIN_LAT register stages.
module usvg_sin #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic [ANGLE_BITS-1:0] phase,
    output logic signed [15:0]    sin_val
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int ZB = ANGLE_BITS - 1;
    localparam logic [ZB-1:0] QUARTER = ZB'(1) << QB;

    logic [1:0]    quad;
    logic [QB-1:0] rest;
    logic [ZB-1:0] zf;

    assign quad = phase[ANGLE_BITS-1:ANGLE_BITS-2];
    assign rest = phase[QB-1:0];
    assign zf   = quad[0] ? (QUARTER - {1'b0, rest}) : {1'b0, rest};

    // stage 1: folded angle in Q1.30
    logic [30:0] z1_reg;
    logic        neg1_reg;

    always_ff @(posedge clk)
    begin
        z1_reg   <= {zf, {(32 - ANGLE_BITS){1'b0}}};
        neg1_reg <= quad[1];
    end

    // stage 2: z^2
    logic [61:0] p2;
    logic [30:0] zz2_reg, z2_reg;
    logic        neg2_reg;

    assign p2 = z1_reg * z1_reg;

    always_ff @(posedge clk)
    begin
        zz2_reg  <= p2[60:30];
        z2_reg   <= z1_reg;
        neg2_reg <= neg1_reg;
    end

    // stage 3: C * z^2
    logic [57:0] p3;
    logic [26:0] t3_reg;
    logic [30:0] zz3_reg, z3_reg;
    logic        neg3_reg;

    assign p3 = usvg_pkg::POLY_C * zz2_reg;

    always_ff @(posedge clk)
    begin
        t3_reg   <= p3[56:30];
        zz3_reg  <= zz2_reg;
        z3_reg   <= z2_reg;
        neg3_reg <= neg2_reg;
    end

    // stage 4: z^2 * (B - C z^2)
    logic [29:0] b4;
    logic [60:0] p4;
    logic [29:0] t4_reg;
    logic [30:0] z4_reg;
    logic        neg4_reg;

    assign b4 = usvg_pkg::POLY_B - 30'(t3_reg);
    assign p4 = zz3_reg * b4;

    always_ff @(posedge clk)
    begin
        t4_reg   <= p4[59:30];
        z4_reg   <= z3_reg;
        neg4_reg <= neg3_reg;
    end

    // stage 5: z * (A - ...)
    logic [30:0] a5;
    logic [61:0] p5;
    logic [31:0] s5_reg;
    logic        neg5_reg;

    assign a5 = usvg_pkg::POLY_A - 31'(t4_reg);
    assign p5 = z4_reg * a5;

    always_ff @(posedge clk)
    begin
        s5_reg   <= p5[61:30];
        neg5_reg <= neg4_reg;
    end

    // stage 6: round to Q1.15, saturate, sign
    logic [32:0] rnd;
    logic [17:0] v17;
    logic [15:0] mag;
    logic signed [15:0] out_reg;

    assign rnd = {1'b0, s5_reg} + 33'd16384;
    assign v17 = rnd[32:15];
    assign mag = (v17 > 18'd32767) ? 16'sd32767 : v17[15:0];

    always_ff @(posedge clk)
    begin
        out_reg <= neg5_reg ? -$signed(mag) : $signed(mag);
    end

    assign sin_val = out_reg;

endmodule

// ===== rtl/uv_sphere_vertex_generator.sv =====
`timescale 1ns / 1ps

// UV sphere vertex generator.
// Command channel: present column/ring with start; the point is taken on any
// edge where start is high and busy is low. busy stays low: the pipeline takes
// one point per clock with no gaps.
// Result channel: done pulses for one cycle with every result port valid;
// the receiver cannot stall, so each result is presented exactly once.
// Path: start to done runs through the capture stage, the bit-per-stage
// angle dividers, the sine units, the normal stage and the output stage;
// texture quotients and side data are delayed to match. Throughput: one point
// per cycle.
// Config port: cfg_we, cfg_index, cfg_data; write only while no point is in
// flight. Index 0 radius (Q8.8), 1 segment count, 2 ring count.
// Reset: config returns to radius 1.0, 16 segments, 8 rings; all in-flight
// points are dropped and done stays low.
// Off-grid points or bad geometry give out_of_range = 1, all else zero.
module uv_sphere_vertex_generator #(
    parameter int MAX_GRID   = usvg_pkg::MAX_GRID_DEF,
    parameter int ANGLE_BITS = usvg_pkg::ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [10:0]        column,
    input  logic [9:0]         ring,
    output logic               done,
    output logic [20:0]        vertex_index,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic signed [15:0] tangent_x,
    output logic signed [15:0] tangent_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               out_of_range
);

    localparam int AB      = ANGLE_BITS;
    localparam int DIV_LAT = (AB + 1 > 17) ? AB + 1 : 17;
    // dividers to the normal stage output
    localparam int SIDE_LAT = DIV_LAT + usvg_pkg::SIN_LAT + 1;
    localparam int SIDE_W   = 21 + 16 + 1;
    localparam logic [AB-1:0] QTR = AB'(1) << (AB - 2);

    // ---------------- configuration ----------------
    logic [15:0] radius_reg;
    logic [10:0] segs_reg, rings_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= usvg_pkg::RADIUS_RST;
            segs_reg   <= usvg_pkg::SEGS_RST;
            rings_reg  <= usvg_pkg::RINGS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                usvg_pkg::CFG_RADIUS: radius_reg <= cfg_data;
                usvg_pkg::CFG_SEGS:   segs_reg   <= cfg_data[10:0];
                usvg_pkg::CFG_RINGS:  rings_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage A: capture the point ----------------
    logic        a_vld_reg;
    logic [10:0] a_x_reg;
    logic [9:0]  a_y_reg;
    logic [15:0] a_rad_reg;
    logic [10:0] a_segs_reg, a_rings_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg     <= column;
        a_y_reg     <= ring;
        a_rad_reg   <= radius_reg;
        a_segs_reg  <= segs_reg;
        a_rings_reg <= rings_reg;
    end

    // grid check, index, dividend setup
    localparam logic [12:0] GRID_MAX = 13'(MAX_GRID);

    logic [10:0]    span;
    logic           a_oor;
    logic [21:0]    a_idx_full;
    logic [AB+11:0] lon_num;
    logic [AB+10:0] lat_num;
    logic [27:0]    u_num, v_num;

    assign span  = a_rings_reg - 11'd1;
    assign a_oor = (a_segs_reg == 11'd0) || ({2'b0, a_segs_reg} > GRID_MAX)
                || (a_rings_reg < 11'd2) || ({2'b0, a_rings_reg} > GRID_MAX)
                || (a_x_reg > a_segs_reg) || ({1'b0, a_y_reg} > span);

    assign a_idx_full = 22'(a_x_reg) * 22'(a_rings_reg) + 22'(a_y_reg);

    assign lon_num = {1'b0, a_x_reg, {AB{1'b0}}} + (AB + 12)'(a_segs_reg >> 1);
    assign lat_num = {2'b0, a_y_reg, {(AB - 1){1'b0}}} + (AB + 11)'(span >> 1);
    assign u_num   = {1'b0, a_x_reg, 16'b0} + 28'(a_segs_reg >> 1);
    assign v_num   = {2'b0, a_y_reg, 16'b0} + 28'(span >> 1);

    // ---------------- dividers ----------------
    logic [AB:0]   lon_q;
    logic [AB-1:0] lat_q;
    logic [16:0]   u_q, v_q;

    usvg_div #(.NUM_W(AB + 12), .QW(AB + 1), .LAT(DIV_LAT)) u_div_lon (
        .clk(clk), .num(lon_num), .den(a_segs_reg), .quot(lon_q)
    );
    usvg_div #(.NUM_W(AB + 11), .QW(AB), .LAT(DIV_LAT)) u_div_lat (
        .clk(clk), .num(lat_num), .den(span), .quot(lat_q)
    );
    // texture quotients are delayed to meet the normal stage
    usvg_div #(.NUM_W(28), .QW(17), .LAT(SIDE_LAT)) u_div_u (
        .clk(clk), .num(u_num), .den(a_segs_reg), .quot(u_q)
    );
    usvg_div #(.NUM_W(28), .QW(17), .LAT(SIDE_LAT)) u_div_v (
        .clk(clk), .num(v_num), .den(span), .quot(v_q)
    );

    // side data: valid, index, radius, range flag
    logic              n_vld;
    logic [SIDE_W-1:0] side_in, side_out;

    assign side_in = {a_idx_full[20:0], a_rad_reg, a_oor};

    usvg_dly #(.W(1), .DEPTH(SIDE_LAT)) u_dly_vld (
        .clk(clk), .rst_n(rst_n), .din(a_vld_reg), .dout(n_vld)
    );
    usvg_dly #(.W(SIDE_W), .DEPTH(SIDE_LAT)) u_dly_side (
        .clk(clk), .rst_n(rst_n), .din(side_in), .dout(side_out)
    );

    // ---------------- angles and sines ----------------
    logic [AB-1:0] lon_ph, lat_ph;
    logic signed [15:0] cl, sl, ca, sa;

    assign lon_ph = lon_q[AB-1:0];
    assign lat_ph = lat_q - QTR;

    usvg_sin #(.ANGLE_BITS(AB)) u_sin_cl (.clk(clk), .phase(lon_ph + QTR), .sin_val(cl));
    usvg_sin #(.ANGLE_BITS(AB)) u_sin_sl (.clk(clk), .phase(lon_ph), .sin_val(sl));
    usvg_sin #(.ANGLE_BITS(AB)) u_sin_ca (.clk(clk), .phase(lat_ph + QTR), .sin_val(ca));
    usvg_sin #(.ANGLE_BITS(AB)) u_sin_sa (.clk(clk), .phase(lat_ph), .sin_val(sa));

    // magnitude of a Q1.15 value
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] r;
        r = v[15] ? 16'(-v) : 16'(v);
        return r;
    endfunction

    // rounded (|a|*|b| + 2^14) >> 15 on magnitudes
    function automatic logic [15:0] mul_mag(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] p;
        p = 33'(a) * 33'(b) + 33'd16384;
        return p[30:15];
    endfunction

    // ---------------- normal stage ----------------
    logic signed [15:0] nx_reg, ny_reg, nz_reg, tx_reg, tz_reg;
    logic [15:0] nxm, nzm;

    assign nxm = mul_mag(mag16(cl), mag16(ca));
    assign nzm = mul_mag(mag16(sl), mag16(ca));

    always_ff @(posedge clk)
    begin
        nx_reg <= (cl[15] ^ ca[15]) ? -$signed(nxm) : $signed(nxm);
        nz_reg <= (sl[15] ^ ca[15]) ? -$signed(nzm) : $signed(nzm);
        ny_reg <= sa;
        tx_reg <= sl;
        tz_reg <= -cl;
    end

    // ---------------- position / output stage ----------------
    logic [20:0] n_idx;
    logic [15:0] n_rad;
    logic        n_oor;
    logic [15:0] pxm, pym, pzm;

    assign {n_idx, n_rad, n_oor} = side_out;

    assign pxm = mul_mag(n_rad, mag16(nx_reg));
    assign pym = mul_mag(n_rad, mag16(ny_reg));
    assign pzm = mul_mag(n_rad, mag16(nz_reg));

    logic done_reg;
    logic [20:0] idx_reg;
    logic signed [16:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] onx_reg, ony_reg, onz_reg, otx_reg, otz_reg;
    logic [16:0] u_reg, v_reg;
    logic oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= n_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg <= n_oor;
        if (n_oor)
        begin
            idx_reg <= '0;
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
            onx_reg <= '0;
            ony_reg <= '0;
            onz_reg <= '0;
            otx_reg <= '0;
            otz_reg <= '0;
            u_reg   <= '0;
            v_reg   <= '0;
        end
        else
        begin
            idx_reg <= n_idx;
            px_reg  <= nx_reg[15] ? -$signed({1'b0, pxm}) : $signed({1'b0, pxm});
            py_reg  <= ny_reg[15] ? -$signed({1'b0, pym}) : $signed({1'b0, pym});
            pz_reg  <= nz_reg[15] ? -$signed({1'b0, pzm}) : $signed({1'b0, pzm});
            onx_reg <= nx_reg;
            ony_reg <= ny_reg;
            onz_reg <= nz_reg;
            otx_reg <= tx_reg;
            otz_reg <= tz_reg;
            u_reg   <= u_q;
            v_reg   <= v_q;
        end
    end

    assign done         = done_reg;
    assign vertex_index = idx_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign pos_z        = pz_reg;
    assign normal_x     = onx_reg;
    assign normal_y     = ony_reg;
    assign normal_z     = onz_reg;
    assign tangent_x    = otx_reg;
    assign tangent_z    = otz_reg;
    assign tex_u        = u_reg;
    assign tex_v        = v_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_LAT = 26;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic [10:0]        column;
    logic [9:0]         ring;
    logic               done;
    logic [20:0]        vertex_index;
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic signed [15:0] tangent_x, tangent_z;
    logic [16:0]        tex_u, tex_v;
    logic               out_of_range;

    // One vertex worth of outputs
    typedef struct packed {
        logic [20:0] idx;
        logic [16:0] px, py, pz;
        logic [15:0] nx, ny, nz;
        logic [15:0] tx, tz;
        logic [16:0] u, v;
        logic        oor;
    } vertex_t;

    // Directed row: point, plus optional typed-in expectation
    typedef struct {
        logic [10:0] col;
        logic [9:0]  rng;
        bit          has_exp;
        vertex_t     exp;
    } stim_row_t;

    vertex_t     vertex_q[$];
    int          errors;
    int          sent;
    logic [15:0] radius_m;
    logic [10:0] segs_m;
    logic [10:0] rings_m;

    uv_sphere_vertex_generator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .column(column), .ring(ring), .done(done),
        .vertex_index(vertex_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .tangent_x(tangent_x), .tangent_z(tangent_z),
        .tex_u(tex_u), .tex_v(tex_v), .out_of_range(out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // Sine of a 16-bit phase, Q1.15, fixed-point odd polynomial
    function automatic longint phase_sin(longint unsigned ph);
        longint unsigned p, q, r, z, z2, t, s, v;
        begin
            p = ph & 64'hFFFF;
            q = p >> 14;
            r = p & 64'h3FFF;
            z = q[0] ? (64'h4000 - r) : r;
            z = z << 16;
            z2 = (z * z) >> 30;
            t = (64'(usvg_pkg::POLY_C) * z2) >> 30;
            t = 64'(usvg_pkg::POLY_B) - t;
            t = (z2 * t) >> 30;
            t = 64'(usvg_pkg::POLY_A) - t;
            s = (z * t) >> 30;
            v = (s + 16384) >> 15;
            if (v > 32767)
                v = 32767;
            phase_sin = q[1] ? -longint'(v) : longint'(v);
        end
    endfunction

    // Signed product on magnitudes, rounded, Q15 shift
    function automatic longint smul_q15(longint a, longint b);
        longint unsigned m;
        begin
            m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + 16384) >> 15;
            smul_q15 = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        end
    endfunction

    function automatic vertex_t vertex_of(logic [10:0] col, logic [9:0] rng);
        vertex_t o;
        longint unsigned x, y, sg, rn, sp, lon, lat;
        longint cl, sl, ca, sa, nx, ny, nz, rad;
        begin
            o = '0;
            x = col;
            y = rng;
            sg = segs_m;
            rn = rings_m;
            if (sg < 1 || sg > 1024 || rn < 2 || rn > 1024 || x > sg || y > rn - 1)
            begin
                o.oor = 1'b1;
            end
            else
            begin
                sp = rn - 1;
                lon = (((x << 16) + sg / 2) / sg) & 64'hFFFF;
                lat = (((y << 15) + sp / 2) / sp);
                lat = (lat - 64'h4000) & 64'hFFFF;
                cl = phase_sin(lon + 64'h4000);
                sl = phase_sin(lon);
                ca = phase_sin(lat + 64'h4000);
                sa = phase_sin(lat);
                nx = smul_q15(cl, ca);
                ny = sa;
                nz = smul_q15(sl, ca);
                rad = longint'(radius_m);
                o.idx = 21'(x * rn + y);
                o.px = 17'(smul_q15(rad, nx));
                o.py = 17'(smul_q15(rad, ny));
                o.pz = 17'(smul_q15(rad, nz));
                o.nx = 16'(nx);
                o.ny = 16'(ny);
                o.nz = 16'(nz);
                o.tx = 16'(sl);
                o.tz = 16'(-cl);
                o.u = 17'(((x << 16) + sg / 2) / sg);
                o.v = 17'(((y << 16) + sp / 2) / sp);
            end
            vertex_of = o;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        end
    endtask

    // Result monitor: done marks a one-cycle transfer, checked against oldest
    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n && done)
        begin
            if (vertex_q.size() == 0)
            begin
                report_mismatch("unexpected", 32'(vertex_index), 32'd0);
            end
            else
            begin
                w = vertex_q.pop_front();
                if (vertex_index !== w.idx)
                    report_mismatch("vertex_index", 32'(vertex_index), 32'(w.idx));
                if (pos_x !== w.px) report_mismatch("pos_x", 32'(pos_x), 32'(w.px));
                if (pos_y !== w.py) report_mismatch("pos_y", 32'(pos_y), 32'(w.py));
                if (pos_z !== w.pz) report_mismatch("pos_z", 32'(pos_z), 32'(w.pz));
                if (normal_x !== w.nx)
                    report_mismatch("normal_x", 32'(normal_x), 32'(w.nx));
                if (normal_y !== w.ny)
                    report_mismatch("normal_y", 32'(normal_y), 32'(w.ny));
                if (normal_z !== w.nz)
                    report_mismatch("normal_z", 32'(normal_z), 32'(w.nz));
                if (tangent_x !== w.tx)
                    report_mismatch("tangent_x", 32'(tangent_x), 32'(w.tx));
                if (tangent_z !== w.tz)
                    report_mismatch("tangent_z", 32'(tangent_z), 32'(w.tz));
                if (tex_u !== w.u) report_mismatch("tex_u", 32'(tex_u), 32'(w.u));
                if (tex_v !== w.v) report_mismatch("tex_v", 32'(tex_v), 32'(w.v));
                if (out_of_range !== w.oor)
                    report_mismatch("out_of_range", 32'(out_of_range), 32'(w.oor));
            end
        end
    end

    // Present one point; hold start until a transfer happens
    task automatic send_point(logic [10:0] col, logic [9:0] rng, bit has_exp, vertex_t exp);
        vertex_t p;
        begin
            start <= 1'b1;
            column <= col;
            ring <= rng;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            p = vertex_of(col, rng);
            if (has_exp && p !== exp)
                report_mismatch("table row", 32'(p.idx), 32'(exp.idx));
            vertex_q.push_back(has_exp ? exp : p);
            sent++;
        end
    endtask

    task automatic idle_cycles(int n);
        begin
            start <= 1'b0;
            column <= 11'($urandom);
            ring <= 10'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Drain, then let the pipe empty out before touching config
    task automatic drain;
        int guard;
        begin
            idle_cycles(1);
            guard = 0;
            while (vertex_q.size() != 0 && guard < 10000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (PIPE_LAT + 4) @(posedge clk);
        end
    endtask

    // One register write, then cfg_we low again on the port before the task returns
    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            if (idx == usvg_pkg::CFG_RADIUS) radius_m = val;
            else if (idx == usvg_pkg::CFG_SEGS) segs_m = val[10:0];
            else if (idx == usvg_pkg::CFG_RINGS) rings_m = val[10:0];
            @(posedge clk);
        end
    endtask

    // Random bursts; most points on the grid, some off it
    task automatic random_phase(int n);
        int k, burst;
        logic [10:0] c;
        logic [9:0] r;
        begin
            k = 0;
            while (k < n)
            begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && k < n)
                begin
                    if ($urandom_range(0, 9) < 8 && segs_m >= 1 && rings_m >= 2)
                    begin
                        c = 11'($urandom_range(0, segs_m > 1024 ? 1024 : segs_m));
                        r = 10'($urandom_range(0, rings_m > 1024 ? 1023 : rings_m - 1));
                    end
                    else
                    begin
                        c = 11'($urandom);
                        r = 10'($urandom);
                    end
                    send_point(c, r, 1'b0, '0);
                    burst--;
                    k++;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 30));
            end
        end
    endtask

    stim_row_t table_rows[$];

    initial
    begin
        stim_row_t row;
        vertex_t e;
        int ph;
        errors = 0;
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = usvg_pkg::CFG_RADIUS;
        cfg_data = '0;
        column = '0;
        ring = '0;
        radius_m = usvg_pkg::RADIUS_RST;
        segs_m = usvg_pkg::SEGS_RST;
        rings_m = usvg_pkg::RINGS_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset geometry (16 x 8, radius 1.0)
        // South pole, column 0: normal (0,-1,0), tangent (0,0,-1)
        e = '0;
        e.py = -17'sd256; e.ny = -16'sd32767; e.tz = -16'sd32767;
        table_rows.push_back('{11'd0, 10'd0, 1'b1, e});
        // North pole
        e = '0;
        e.idx = 21'd7; e.py = 17'sd256; e.ny = 16'sd32767; e.tz = -16'sd32767;
        e.v = 17'd65536;
        table_rows.push_back('{11'd0, 10'd7, 1'b1, e});
        // Off the grid: ring past last, column past closing, both at maximum
        e = '0; e.oor = 1'b1;
        table_rows.push_back('{11'd0, 10'd8, 1'b1, e});
        table_rows.push_back('{11'd17, 10'd0, 1'b1, e});
        table_rows.push_back('{11'h7FF, 10'h3FF, 1'b1, e});
        // Closing column at an interior ring and at the pole, mid points (predicted)
        table_rows.push_back('{11'd16, 10'd3, 1'b0, '0});
        table_rows.push_back('{11'd16, 10'd7, 1'b0, '0});
        table_rows.push_back('{11'd4, 10'd3, 1'b0, '0});
        table_rows.push_back('{11'd8, 10'd4, 1'b0, '0});
        table_rows.push_back('{11'd12, 10'd5, 1'b0, '0});
        table_rows.push_back('{11'd1, 10'd1, 1'b0, '0});
        foreach (table_rows[i])
            send_point(table_rows[i].col, table_rows[i].rng, table_rows[i].has_exp,
                       table_rows[i].exp);
        drain();

        // Several geometries, extremes included; short random phase each
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(usvg_pkg::CFG_RADIUS, 16'hFFFF);
                    write_cfg(usvg_pkg::CFG_SEGS, 16'd1);
                    write_cfg(usvg_pkg::CFG_RINGS, 16'd2);
                end
                1:
                begin
                    write_cfg(usvg_pkg::CFG_RADIUS, 16'd0);
                    write_cfg(usvg_pkg::CFG_SEGS, 16'd1024);
                    write_cfg(usvg_pkg::CFG_RINGS, 16'd1024);
                end
                2:
                begin
                    write_cfg(usvg_pkg::CFG_RADIUS, 16'h0180);
                    write_cfg(usvg_pkg::CFG_SEGS, 16'd3);
                    write_cfg(usvg_pkg::CFG_RINGS, 16'd5);
                end
                // Invalid geometry: everything out of range
                3:
                begin
                    write_cfg(usvg_pkg::CFG_SEGS, 16'd0);
                    write_cfg(usvg_pkg::CFG_RINGS, 16'd1);
                end
                4:
                begin
                    write_cfg(usvg_pkg::CFG_SEGS, 16'h07FF);
                    write_cfg(usvg_pkg::CFG_RINGS, 16'h07FF);
                end
                default:
                begin
                    write_cfg(usvg_pkg::CFG_RADIUS, 16'($urandom));
                    write_cfg(usvg_pkg::CFG_SEGS, 16'($urandom_range(1, 1024)));
                    write_cfg(usvg_pkg::CFG_RINGS, 16'($urandom_range(2, 1024)));
                end
            endcase
            // Edge points for this geometry
            if (ph < 3)
            begin
                send_point(segs_m, 10'(rings_m - 1), 1'b0, '0);
                send_point(11'd0, 10'(rings_m - 1), 1'b0, '0);
            end
            random_phase(ph < 3 || ph > 4 ? 230 : 60);
            drain();
        end

        if (errors == 0 && vertex_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/usvg_pkg.sv
rtl/usvg_dly.sv
rtl/usvg_div.sv
rtl/usvg_sin.sv
rtl/uv_sphere_vertex_generator.sv
dv/testbench.sv
